>>> hdl/gsp_pkg.sv
package gsp_pkg;

  localparam int MaxVertices = 16;
  localparam int VtxBits     = 4;
  localparam int CntBits     = 5;
  localparam int CostBits    = 16;
  localparam int DistBits    = 20;
  localparam int TableBits   = 2 * VtxBits;
  localparam int DmBits      = DistBits + VtxBits;

  localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};
  localparam logic [CntBits-1:0]  VcReset = 5'd16;
  localparam logic [CntBits-1:0]  VcMin   = 5'd2;

  localparam logic RegVertexCount = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_VERTEX  = 2'd1,
    ST_NO_ROAD     = 2'd2,
    ST_UNREACHABLE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDIT,
    S_RELAX,
    S_CHECK,
    S_WALK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic                upd;
    logic [DistBits-1:0] dist_sum;
  } relax_t;

endpackage

>>> hdl/gsp_relax.sv
module gsp_relax (
  input  logic                          present_i,
  input  logic                          settled_i,
  input  logic                          reached_i,
  input  logic [gsp_pkg::DistBits-1:0]  old_dist_i,
  input  logic [gsp_pkg::DistBits-1:0]  best_i,
  input  logic [gsp_pkg::CostBits-1:0]  cost_i,
  output gsp_pkg::relax_t               relax_o
);

  logic [gsp_pkg::DistBits:0]   sum;
  logic [gsp_pkg::DistBits-1:0] sat;

  assign sum = {1'b0, best_i} + (gsp_pkg::DistBits + 1)'(cost_i);
  assign sat = sum[gsp_pkg::DistBits] ? gsp_pkg::DistMax : sum[gsp_pkg::DistBits-1:0];

  always_comb begin
    relax_o.dist_sum = sat;
    relax_o.upd      = present_i && !settled_i && (!reached_i || (sat < old_dist_i));
  end

endmodule

>>> hdl/graph_shortest_path_engine.sv
// Shortest-path engine over an undirected weighted road table of 16 vertex slots. An item
// is accepted when start_i is high and busy_o is low; each result is shown for one cycle
// with result_valid_o and cannot be held off. Delete and failed edits give their result
// directly from the idle state; add and update pass through S_EDIT first, for the two
// directions of the road. A query settles one vertex per pass through the distance
// memory, whose single read port handles one vertex per cycle. The road table is empty
// right after reset.
module graph_shortest_path_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    opcode_i,
  input  logic [gsp_pkg::VtxBits-1:0]   first_vertex_i,
  input  logic [gsp_pkg::VtxBits-1:0]   second_vertex_i,
  input  logic [15:0]                   road_cost_i,
  output logic                          result_valid_o,
  output logic [gsp_pkg::VtxBits-1:0]   path_vertex_o,
  output logic [gsp_pkg::DistBits-1:0]  total_cost_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int NV = gsp_pkg::MaxVertices;
  localparam int VB = gsp_pkg::VtxBits;
  localparam int CB = gsp_pkg::CntBits;
  localparam int DB = gsp_pkg::DistBits;
  localparam int KB = gsp_pkg::CostBits;
  localparam int TB = gsp_pkg::TableBits;
  localparam int MB = gsp_pkg::DmBits;
  localparam int TableDepth = NV * NV;

  gsp_pkg::state_e state_q, state_d;

  logic [CB-1:0] vc_q, vc_d;
  logic [CB-1:0] eff_n;

  logic [TableDepth-1:0] present_q, present_d;

  logic [KB-1:0] cost_mem [TableDepth];
  logic [KB-1:0] cost_rd_q;
  logic          cost_we;
  logic [TB-1:0] cost_waddr, cost_raddr;
  logic [KB-1:0] cost_wdata;

  logic [MB-1:0] dm_mem [NV];
  logic [MB-1:0] dm_rd_q;
  logic          dm_we;
  logic [VB-1:0] dm_waddr, dm_raddr;
  logic [MB-1:0] dm_wdata;

  logic [VB-1:0] src_q, src_d, dst_q, dst_d;
  logic [VB-1:0] a_q, a_d, b_q, b_d;
  logic [KB-1:0] cost_q, cost_d;
  logic [VB-1:0] bi_q, bi_d;
  logic [DB-1:0] best_q, best_d;
  logic [CB-1:0] sc_q, sc_d;
  logic          p_vld_q, p_vld_d;
  logic [VB-1:0] p_idx_q, p_idx_d;
  logic          found_q, found_d;
  logic [DB-1:0] min_q, min_d;
  logic [VB-1:0] min_idx_q, min_idx_d;
  logic [NV-1:0] reached_q, reached_d, settled_q, settled_d;
  logic [VB-1:0] chain_q [NV];
  logic [VB-1:0] chain_d [NV];
  logic [CB-1:0] len_q, len_d;
  logic [VB-1:0] k_q, k_d;
  logic [DB-1:0] total_q, total_d;

  logic                res_vld_q, res_vld_d;
  logic [VB-1:0]       res_vtx_q, res_vtx_d;
  logic [DB-1:0]       res_cost_q, res_cost_d;
  gsp_pkg::status_e    res_status_q, res_status_d;
  logic                res_last_q, res_last_d;

  logic          accept;
  logic          vtx_ok;
  logic          present_ab;
  logic          pass_end;
  logic          cand;
  logic          found_nxt;
  logic [DB-1:0] new_dist;
  logic          new_reached;
  logic [DB-1:0] min_nxt;
  logic [VB-1:0] min_idx_nxt;
  logic [VB-1:0] walk_v;
  logic          walk_stop;
  logic [NV-1:0] src_onehot;
  gsp_pkg::relax_t rx;
  gsp_pkg::opcode_e op;

  assign op         = gsp_pkg::opcode_e'(opcode_i);
  assign accept     = start_i && (state_q == gsp_pkg::S_IDLE);
  assign busy_o     = (state_q != gsp_pkg::S_IDLE);
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == gsp_pkg::RegVertexCount) ? {27'b0, vc_q} : 32'b0;

  always_comb begin
    if (vc_q < gsp_pkg::VcMin) begin
      eff_n = gsp_pkg::VcMin;
    end else if (vc_q > CB'(NV)) begin
      eff_n = CB'(NV);
    end else begin
      eff_n = vc_q;
    end
  end

  always_comb begin
    vc_d = vc_q;
    if (psel && penable && pwrite && (paddr[2] == gsp_pkg::RegVertexCount)) begin
      vc_d = pwdata[CB-1:0];
    end
  end

  assign vtx_ok = ({1'b0, first_vertex_i} < eff_n) && ({1'b0, second_vertex_i} < eff_n)
                  && (first_vertex_i != second_vertex_i);
  assign present_ab = present_q[{first_vertex_i, second_vertex_i}];
  assign src_onehot = {{(NV-1){1'b0}}, 1'b1} << first_vertex_i;

  gsp_relax u_relax (
    .present_i  (present_q[{bi_q, p_idx_q}]),
    .settled_i  (settled_q[p_idx_q]),
    .reached_i  (reached_q[p_idx_q]),
    .old_dist_i (dm_rd_q[MB-1:VB]),
    .best_i     (best_q),
    .cost_i     (cost_rd_q),
    .relax_o    (rx)
  );

  assign new_reached = reached_q[p_idx_q] || rx.upd;
  assign new_dist    = rx.upd ? rx.dist_sum : dm_rd_q[MB-1:VB];
  assign cand        = p_vld_q && new_reached && !settled_q[p_idx_q]
                       && (!found_q || (new_dist < min_q));
  assign found_nxt   = found_q || cand;
  assign min_nxt     = cand ? new_dist : min_q;
  assign min_idx_nxt = cand ? p_idx_q : min_idx_q;
  assign pass_end    = p_vld_q && (sc_q == eff_n);

  assign walk_v    = dm_rd_q[VB-1:0];
  assign walk_stop = (walk_v == src_q) || ((len_q + CB'(1)) == eff_n);

  always_comb begin
    state_d = state_q;
    case (state_q)
      gsp_pkg::S_IDLE: begin
        if (accept && vtx_ok) begin
          case (op)
            gsp_pkg::OP_ADD:    state_d = gsp_pkg::S_EDIT;
            gsp_pkg::OP_UPDATE: state_d = present_ab ? gsp_pkg::S_EDIT : gsp_pkg::S_IDLE;
            gsp_pkg::OP_DELETE: state_d = gsp_pkg::S_IDLE;
            default:            state_d = gsp_pkg::S_RELAX;
          endcase
        end
      end
      gsp_pkg::S_EDIT:  state_d = gsp_pkg::S_IDLE;
      gsp_pkg::S_RELAX: begin
        if (pass_end && !found_nxt) begin
          state_d = gsp_pkg::S_CHECK;
        end
      end
      gsp_pkg::S_CHECK: state_d = reached_q[dst_q] ? gsp_pkg::S_WALK : gsp_pkg::S_IDLE;
      gsp_pkg::S_WALK: begin
        if (walk_stop) begin
          state_d = gsp_pkg::S_EMIT;
        end
      end
      gsp_pkg::S_EMIT: begin
        if (k_q == '0) begin
          state_d = gsp_pkg::S_IDLE;
        end
      end
      default: state_d = gsp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    present_d    = present_q;
    src_d        = src_q;
    dst_d        = dst_q;
    a_d          = a_q;
    b_d          = b_q;
    cost_d       = cost_q;
    bi_d         = bi_q;
    best_d       = best_q;
    sc_d         = sc_q;
    p_vld_d      = 1'b0;
    p_idx_d      = p_idx_q;
    found_d      = found_q;
    min_d        = min_q;
    min_idx_d    = min_idx_q;
    reached_d    = reached_q;
    settled_d    = settled_q;
    chain_d      = chain_q;
    len_d        = len_q;
    k_d          = k_q;
    total_d      = total_q;
    res_vld_d    = 1'b0;
    res_vtx_d    = '0;
    res_cost_d   = '0;
    res_status_d = gsp_pkg::ST_OK;
    res_last_d   = 1'b1;
    cost_we      = 1'b0;
    cost_waddr   = '0;
    cost_wdata   = '0;
    cost_raddr   = '0;
    dm_we        = 1'b0;
    dm_waddr     = '0;
    dm_wdata     = '0;
    dm_raddr     = '0;

    case (state_q)
      gsp_pkg::S_IDLE: begin
        if (accept) begin
          src_d  = first_vertex_i;
          dst_d  = second_vertex_i;
          a_d    = first_vertex_i;
          b_d    = second_vertex_i;
          cost_d = road_cost_i[KB-1:0];
          if (!vtx_ok) begin
            res_vld_d    = 1'b1;
            res_status_d = gsp_pkg::ST_BAD_VERTEX;
          end else begin
            case (op)
              gsp_pkg::OP_ADD, gsp_pkg::OP_UPDATE: begin
                if (present_ab || (op == gsp_pkg::OP_ADD)) begin
                  present_d[{first_vertex_i, second_vertex_i}] = 1'b1;
                  present_d[{second_vertex_i, first_vertex_i}] = 1'b1;
                  cost_we    = 1'b1;
                  cost_waddr = {first_vertex_i, second_vertex_i};
                  cost_wdata = road_cost_i[KB-1:0];
                end else begin
                  res_vld_d    = 1'b1;
                  res_status_d = gsp_pkg::ST_NO_ROAD;
                end
              end
              gsp_pkg::OP_DELETE: begin
                res_vld_d = 1'b1;
                if (present_ab) begin
                  present_d[{first_vertex_i, second_vertex_i}] = 1'b0;
                  present_d[{second_vertex_i, first_vertex_i}] = 1'b0;
                end else begin
                  res_status_d = gsp_pkg::ST_NO_ROAD;
                end
              end
              default: begin
                reached_d = src_onehot;
                settled_d = src_onehot;
                bi_d      = first_vertex_i;
                best_d    = '0;
                sc_d      = '0;
                found_d   = 1'b0;
                dm_we     = 1'b1;
                dm_waddr  = first_vertex_i;
                dm_wdata  = {{DB{1'b0}}, first_vertex_i};
              end
            endcase
          end
        end
      end
      gsp_pkg::S_EDIT: begin
        cost_we    = 1'b1;
        cost_waddr = {b_q, a_q};
        cost_wdata = cost_q;
        res_vld_d  = 1'b1;
      end
      gsp_pkg::S_RELAX: begin
        if (sc_q < eff_n) begin
          cost_raddr = {bi_q, sc_q[VB-1:0]};
          dm_raddr   = sc_q[VB-1:0];
          sc_d       = sc_q + CB'(1);
          p_vld_d    = 1'b1;
          p_idx_d    = sc_q[VB-1:0];
        end
        if (p_vld_q) begin
          if (rx.upd) begin
            dm_we              = 1'b1;
            dm_waddr           = p_idx_q;
            dm_wdata           = {rx.dist_sum, bi_q};
            reached_d[p_idx_q] = 1'b1;
          end
          found_d   = found_nxt;
          min_d     = min_nxt;
          min_idx_d = min_idx_nxt;
        end
        if (pass_end) begin
          sc_d    = '0;
          found_d = 1'b0;
          if (found_nxt) begin
            bi_d                   = min_idx_nxt;
            best_d                 = min_nxt;
            settled_d[min_idx_nxt] = 1'b1;
          end
        end
      end
      gsp_pkg::S_CHECK: begin
        if (!reached_q[dst_q]) begin
          res_vld_d    = 1'b1;
          res_status_d = gsp_pkg::ST_UNREACHABLE;
        end else begin
          dm_raddr   = dst_q;
          chain_d[0] = dst_q;
          len_d      = CB'(1);
        end
      end
      gsp_pkg::S_WALK: begin
        if (len_q == CB'(1)) begin
          total_d = dm_rd_q[MB-1:VB];
        end
        chain_d[len_q[VB-1:0]] = walk_v;
        len_d                  = len_q + CB'(1);
        if (walk_stop) begin
          k_d = len_q[VB-1:0];
        end else begin
          dm_raddr = walk_v;
        end
      end
      gsp_pkg::S_EMIT: begin
        res_vld_d = 1'b1;
        res_vtx_d = chain_q[k_q];
        if (k_q == '0) begin
          res_cost_d = total_q;
        end else begin
          res_last_d = 1'b0;
          k_d        = k_q - VB'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    cost_rd_q <= cost_mem[cost_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    dm_rd_q <= dm_mem[dm_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gsp_pkg::S_IDLE;
      vc_q      <= gsp_pkg::VcReset;
      present_q <= '0;
      p_vld_q   <= 1'b0;
      found_q   <= 1'b0;
      reached_q <= '0;
      settled_q <= '0;
      sc_q      <= '0;
      len_q     <= '0;
      k_q       <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vc_q      <= vc_d;
      present_q <= present_d;
      p_vld_q   <= p_vld_d;
      found_q   <= found_d;
      reached_q <= reached_d;
      settled_q <= settled_d;
      sc_q      <= sc_d;
      len_q     <= len_d;
      k_q       <= k_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q        <= src_d;
    dst_q        <= dst_d;
    a_q          <= a_d;
    b_q          <= b_d;
    cost_q       <= cost_d;
    bi_q         <= bi_d;
    best_q       <= best_d;
    p_idx_q      <= p_idx_d;
    min_q        <= min_d;
    min_idx_q    <= min_idx_d;
    chain_q      <= chain_d;
    total_q      <= total_d;
    res_vtx_q    <= res_vtx_d;
    res_cost_q   <= res_cost_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o = res_vld_q;
  assign path_vertex_o  = res_vtx_q;
  assign total_cost_o   = res_cost_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

endmodule
